FILE: rtl/vvbs_pkg.sv
`default_nettype none

package vvbs_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_SENSOR_SPAN       = 4096;
    localparam int DEF_SENSOR_FULL_MMH2O = 1000;

    // Fixed tuning constants
    localparam int TICK_MS        = 10;
    localparam int PRESSURE_STEP  = 1;
    localparam int POSITION_LIMIT = 1000;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_INSPIRATION_TIME = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRATION_TIME  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_PRESSURE     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_VOLUME       = 8'd3;

    // Register reset values
    localparam logic [15:0] RST_INSPIRATION_TIME = 16'd1000;
    localparam logic [15:0] RST_EXPIRATION_TIME  = 16'd2000;
    localparam logic [15:0] RST_SET_PRESSURE     = 16'd200;
    localparam logic [12:0] RST_SET_VOLUME       = 13'd500;

    typedef enum logic [2:0] {
        PHASE_INIT      = 3'd0,
        PHASE_HOME      = 3'd1,
        PHASE_WAIT_HOME = 3'd2,
        PHASE_EXPIRE    = 3'd3,
        PHASE_START     = 3'd4,
        PHASE_INHALE    = 3'd6,
        PHASE_HOLD      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        DRV_KEEP     = 2'd0,
        DRV_HOME     = 2'd1,
        DRV_REGULATE = 2'd2,
        DRV_STOP     = 2'd3
    } drive_cmd_t;

    typedef enum logic [1:0] {
        VOL_NONE      = 2'd0,
        VOL_RESET     = 2'd1,
        VOL_INTEGRATE = 2'd2
    } vol_cmd_t;

    typedef struct packed {
        logic               motor_stopped;
        logic               mode_change_request;
        logic signed [15:0] flow_ml_s;
        logic signed [23:0] volume_tenth_ml;
        logic        [15:0] actuator_position;
    } in_item_t;

    typedef struct packed {
        logic        [2:0]  status_code;
        logic        [1:0]  drive_command;
        logic signed [31:0] pressure_target;
        logic        [1:0]  volume_command;
        logic        [15:0] breath_count;
        logic               mode_handoff;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/volume_ventilation_breath_sequencer.sv
`default_nettype none

// Channel   Ports                                   Dir  Beat
// ------    --------------------------------------  ---  --------------------------
// s_        s_valid, s_ready, s_data (in_item_t)    in   one control tick
// m_        m_valid, m_ready, m_data (out_item_t)   out  one result per tick
// cfg_      cfg_valid, cfg_ready, cfg_index/data    in   one register write
//
// One tick is accepted per cycle while s_ready is high; its result is in the output register in the next cycle.
// A tick is accepted while the previous result waits, as long as m_ready takes it in
// that same cycle; s_ready is low only while a result waits and m_ready is low.
// The scaled pressure set point is formed in the cycle of a set-pressure write, so
// there is no stall after reset or after a write.
// aresetn is synchronous, active low; config writes are always taken (cfg_ready high).
module volume_ventilation_breath_sequencer
    import vvbs_pkg::*;
#(
    parameter int SENSOR_SPAN       = DEF_SENSOR_SPAN,
    parameter int SENSOR_FULL_MMH2O = DEF_SENSOR_FULL_MMH2O
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_data,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_data,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW = 16 + $clog2(SENSOR_SPAN + 1);
    localparam int RAMP_W = 16 + $clog2(PRESSURE_STEP + 2);

    // SENSOR_SPAN / SENSOR_FULL_MMH2O in fixed point, rounded up; the fraction bits keep the
    // floor exact for every 16-bit set pressure
    localparam int     SCALE_SHIFT = 16 + $clog2(SENSOR_FULL_MMH2O);
    localparam longint SCALE_K     = ((longint'(SENSOR_SPAN) << SCALE_SHIFT)
                                      + longint'(SENSOR_FULL_MMH2O) - 1)
                                     / longint'(SENSOR_FULL_MMH2O);
    localparam int     KW          = $clog2(SCALE_K + 1);
    localparam int     PW          = 16 + KW;
    localparam logic [XW-1:0] SCALED_RST =
        XW'((PW'(RST_SET_PRESSURE) * PW'(SCALE_K)) >> SCALE_SHIFT);

    // configuration registers
    logic [15:0] insp_time_reg;
    logic [15:0] exp_time_reg;
    logic [XW-1:0] scaled_press_reg;
    logic [12:0] set_vol_reg;

    // latched copies
    logic [15:0] lat_insp_reg;
    logic [15:0] lat_exp_reg;
    logic [12:0] lat_vol_reg;

    // breath state
    phase_t      phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [31:0] goal_reg, goal_next;
    logic [15:0] breaths_reg, breaths_next;
    logic        latch_en;

    // output register
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    drive_cmd_t  drive_cmd;
    vol_cmd_t    vol_cmd;
    logic        handoff;

    logic [PW-1:0] press_prod;

    logic          s_accept;
    logic [15:0]   elapsed_inc;
    logic [31:0]   start_goal;
    logic [RAMP_W-1:0] ramp;

    logic signed [17:0] flow_ext;
    logic signed [17:0] flow_x3;
    logic signed [17:0] flow_off;
    logic signed [18:0] vol_diff;
    logic signed [23:0] vol_diff_w;
    logic signed [23:0] vol_limit;
    logic               limit_hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // set_press * SENSOR_SPAN / SENSOR_FULL_MMH2O, taken from the write data
    assign press_prod = PW'(cfg_data) * PW'(SCALE_K);

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            insp_time_reg    <= RST_INSPIRATION_TIME;
            exp_time_reg     <= RST_EXPIRATION_TIME;
            scaled_press_reg <= SCALED_RST;
            set_vol_reg      <= RST_SET_VOLUME;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INSPIRATION_TIME: insp_time_reg <= cfg_data;
                CFG_EXPIRATION_TIME:  exp_time_reg  <= cfg_data;
                CFG_SET_PRESSURE:     scaled_press_reg <= XW'(press_prod >> SCALE_SHIFT);
                CFG_SET_VOLUME:       set_vol_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Tick datapath
    //------------------------------------------------------------------
    assign elapsed_inc = elapsed_reg + 16'(TICK_MS);
    assign ramp        = RAMP_W'(insp_time_reg) * RAMP_W'(PRESSURE_STEP);
    assign start_goal  = 32'(scaled_press_reg) - 32'(ramp);

    // volume limit: 10 * (set_volume - trunc(3 * flow / 4))
    assign flow_ext   = 18'($signed(s_data.flow_ml_s));
    assign flow_x3    = flow_ext + (flow_ext <<< 1);
    assign flow_off   = flow_x3[17] ? ((flow_x3 + 18'sd3) >>> 2) : (flow_x3 >>> 2);
    assign vol_diff   = $signed({6'b0, lat_vol_reg}) - 19'(flow_off);
    assign vol_diff_w = 24'(vol_diff);
    assign vol_limit  = (vol_diff_w <<< 3) + (vol_diff_w <<< 1);
    assign limit_hit  = ($signed(s_data.volume_tenth_ml) > vol_limit)
                     || (s_data.actuator_position >= 16'(POSITION_LIMIT));

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PHASE_INIT:      phase_next = PHASE_HOME;
            PHASE_HOME:      phase_next = PHASE_WAIT_HOME;
            PHASE_WAIT_HOME: begin
                if (s_data.motor_stopped) phase_next = PHASE_EXPIRE;
            end
            PHASE_EXPIRE: begin
                if (elapsed_inc > lat_exp_reg) phase_next = PHASE_START;
            end
            PHASE_START: begin
                phase_next = s_data.mode_change_request ? PHASE_INIT : PHASE_INHALE;
            end
            PHASE_INHALE: begin
                // a limit hit wins over the time-out
                if (limit_hit) begin
                    phase_next = PHASE_HOLD;
                end else if (elapsed_inc > lat_insp_reg) begin
                    phase_next = PHASE_HOME;
                end
            end
            PHASE_HOLD: begin
                if (elapsed_inc > lat_insp_reg) phase_next = PHASE_HOME;
            end
            default:         phase_next = PHASE_HOME;
        endcase
    end

    // commands and counters
    always_comb begin
        drive_cmd    = DRV_KEEP;
        vol_cmd      = VOL_NONE;
        handoff      = 1'b0;
        latch_en     = 1'b0;
        elapsed_next = elapsed_reg;
        goal_next    = goal_reg;
        breaths_next = breaths_reg;
        unique case (phase_reg) inside
            PHASE_INIT: latch_en = 1'b1;
            PHASE_HOME: begin
                drive_cmd    = DRV_HOME;
                elapsed_next = '0;
            end
            PHASE_WAIT_HOME, PHASE_EXPIRE: elapsed_next = elapsed_inc;
            PHASE_START: begin
                if (s_data.mode_change_request) begin
                    handoff = 1'b1;
                end else begin
                    latch_en     = 1'b1;
                    vol_cmd      = VOL_RESET;
                    breaths_next = breaths_reg + 16'd1;
                    drive_cmd    = DRV_REGULATE;
                    elapsed_next = '0;
                    goal_next    = start_goal;
                end
            end
            PHASE_INHALE: begin
                vol_cmd      = VOL_INTEGRATE;
                elapsed_next = elapsed_inc;
                goal_next    = goal_reg + 32'(PRESSURE_STEP);
            end
            PHASE_HOLD: begin
                drive_cmd    = DRV_STOP;
                elapsed_next = elapsed_inc;
            end
            default: drive_cmd = DRV_STOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_INIT;
            elapsed_reg  <= '0;
            goal_reg     <= '0;
            breaths_reg  <= '0;
            lat_insp_reg <= '0;
            lat_exp_reg  <= '0;
            lat_vol_reg  <= '0;
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            goal_reg    <= goal_next;
            breaths_reg <= breaths_next;
            if (latch_en) begin
                lat_insp_reg <= insp_time_reg;
                lat_exp_reg  <= exp_time_reg;
                lat_vol_reg  <= set_vol_reg;
            end
        end
    end

    //------------------------------------------------------------------
    // Result register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.status_code     <= phase_reg;
            m_data_reg.drive_command   <= drive_cmd;
            m_data_reg.pressure_target <= $signed(goal_next);
            m_data_reg.volume_command  <= vol_cmd;
            m_data_reg.breath_count    <= breaths_next;
            m_data_reg.mode_handoff    <= handoff;
        end
    end

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted tick produced no result");

    a_breath_with_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ((m_data.breath_count != $past(breaths_reg))
                      == (m_data.volume_command == VOL_RESET)))
        else $error("breath count and integrator reset out of step");

    a_handoff_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.mode_handoff) |-> (m_data.status_code == PHASE_START))
        else $error("mode handoff outside start phase");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in the output register");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import vvbs_pkg::*;

    localparam int SPAN = DEF_SENSOR_SPAN;
    localparam int FULL_SCALE = DEF_SENSOR_FULL_MMH2O;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 8'hFF;

    logic aclk = 1'b0;
    logic aresetn;

    logic s_valid;
    logic s_ready;
    in_item_t s_data;

    logic m_valid;
    logic m_ready;
    out_item_t m_data;

    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    always #5 aclk = ~aclk;

    volume_ventilation_breath_sequencer #(
        .SENSOR_SPAN(SPAN),
        .SENSOR_FULL_MMH2O(FULL_SCALE)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Sequencer mirror: live registers, copies latched at init/start, breath state
    logic [15:0] set_insp = RST_INSPIRATION_TIME;
    logic [15:0] set_exp = RST_EXPIRATION_TIME;
    logic [15:0] set_press = RST_SET_PRESSURE;
    logic [12:0] set_vol = RST_SET_VOLUME;
    logic [15:0] lat_insp = '0;
    logic [15:0] lat_exp = '0;
    logic [15:0] lat_press = '0;
    logic [12:0] lat_vol = '0;
    logic [2:0] ph = PHASE_INIT;
    logic [15:0] elapsed = '0;
    logic [31:0] goal = '0;
    logic [15:0] breaths = '0;

    out_item_t pending_reports[$];
    int mismatches = 0;
    bit steady;
    int sink_hold;

    function automatic void latch_settings();
        lat_insp = set_insp;
        lat_exp = set_exp;
        lat_press = set_press;
        lat_vol = set_vol;
    endfunction

    // Volume above this (tenths of ml) ends inspiration early; lead truncates toward zero
    function automatic longint volume_ceiling(input logic signed [15:0] flow);
        longint lead;
        lead = (longint'(flow) * 3) / 4;
        return longint'(lat_vol) * 10 - lead * 10;
    endfunction

    function automatic out_item_t breath_step(input in_item_t t);
        out_item_t r;
        logic [63:0] scaled;
        longint vol_now;
        bit hit;
        r = '0;
        r.status_code = ph;
        r.drive_command = DRV_KEEP;
        r.volume_command = VOL_NONE;
        case (ph)
            PHASE_INIT: begin
                latch_settings();
                ph = PHASE_HOME;
            end
            PHASE_HOME: begin
                r.drive_command = DRV_HOME;
                elapsed = '0;
                ph = PHASE_WAIT_HOME;
            end
            PHASE_WAIT_HOME: begin
                elapsed = elapsed + 16'(TICK_MS);
                if (t.motor_stopped)
                    ph = PHASE_EXPIRE;
            end
            PHASE_EXPIRE: begin
                elapsed = elapsed + 16'(TICK_MS);
                if (elapsed > lat_exp)
                    ph = PHASE_START;
            end
            PHASE_START: begin
                if (t.mode_change_request) begin
                    r.mode_handoff = 1'b1;
                    ph = PHASE_INIT;
                end else begin
                    latch_settings();
                    r.volume_command = VOL_RESET;
                    breaths = breaths + 16'd1;
                    r.drive_command = DRV_REGULATE;
                    elapsed = '0;
                    scaled = (64'(lat_press) * 64'(SPAN)) / 64'(FULL_SCALE);
                    goal = 32'(scaled - 64'(lat_insp) * 64'(PRESSURE_STEP));
                    ph = PHASE_INHALE;
                end
            end
            PHASE_INHALE: begin
                r.volume_command = VOL_INTEGRATE;
                elapsed = elapsed + 16'(TICK_MS);
                goal = goal + 32'(PRESSURE_STEP);
                vol_now = $signed(t.volume_tenth_ml);
                hit = (vol_now > volume_ceiling(t.flow_ml_s)) ||
                      (t.actuator_position >= 16'(POSITION_LIMIT));
                if (hit)
                    ph = PHASE_HOLD;
                else if (elapsed > lat_insp)
                    ph = PHASE_HOME;
            end
            PHASE_HOLD: begin
                r.drive_command = DRV_STOP;
                elapsed = elapsed + 16'(TICK_MS);
                if (elapsed > lat_insp)
                    ph = PHASE_HOME;
            end
            default: begin
                r.drive_command = DRV_STOP;
                ph = PHASE_HOME;
            end
        endcase
        r.pressure_target = goal;
        r.breath_count = breaths;
        return r;
    endfunction

    function automatic in_item_t make_tick(input bit stopped, input bit change,
                                           input logic [15:0] flow, input logic [23:0] vol,
                                           input logic [15:0] pos);
        in_item_t t;
        t.motor_stopped = stopped;
        t.mode_change_request = change;
        t.flow_ml_s = flow;
        t.volume_tenth_ml = vol;
        t.actuator_position = pos;
        return t;
    endfunction

    // Motor at rest, no mode change, no limit anywhere
    function automatic in_item_t calm_tick();
        return make_tick(1'b1, 1'b0, 16'd0, 24'h800000, 16'd0);
    endfunction

    function automatic in_item_t random_tick();
        in_item_t t;
        t.motor_stopped = ($urandom_range(0, 3) != 0);
        t.mode_change_request = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
            t.flow_ml_s = 16'($urandom);
        else
            t.flow_ml_s = 16'($urandom_range(0, 100) - 50);
        case ($urandom_range(0, 7))
            0: t.volume_tenth_ml = 24'($urandom);
            1: t.volume_tenth_ml =
                   24'(volume_ceiling(t.flow_ml_s) + int'($urandom_range(0, 4)) - 2);
            default: t.volume_tenth_ml = 24'(-int'($urandom_range(400, 5000)));
        endcase
        case ($urandom_range(0, 7))
            0: t.actuator_position = 16'($urandom);
            1: t.actuator_position = 16'(POSITION_LIMIT - 5 + $urandom_range(0, 10));
            default: t.actuator_position = 16'($urandom_range(0, 900));
        endcase
        return t;
    endfunction

    function automatic logic [15:0] pick_duration();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic push_tick(input in_item_t t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        pending_reports.push_back(breath_step(t));
    endtask

    task automatic settle();
        if (s_valid)
            s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INSPIRATION_TIME: set_insp = val;
            CFG_EXPIRATION_TIME: set_exp = val;
            CFG_SET_PRESSURE: set_press = val;
            CFG_SET_VOLUME: set_vol = val[12:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic advance_to(input phase_t target);
        while (ph != target) push_tick(calm_tick());
    endtask

    task automatic test_random_breaths(input int n_items, input bit retune, input bit squeeze);
        if (retune) begin
            settle();
            write_reg(CFG_INSPIRATION_TIME, pick_duration());
            write_reg(CFG_EXPIRATION_TIME, pick_duration());
            write_reg(CFG_SET_PRESSURE, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SET_VOLUME, 16'($urandom));
            else
                write_reg(CFG_SET_VOLUME, 16'($urandom_range(0, 1000)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE_INDEX, 16'($urandom));
        end
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            // sink backs off while ticks keep coming, so the input stalls
            if (squeeze && k == n_items / 2)
                sink_hold = 64;
            push_tick(random_tick());
        end
        steady = 1'b0;
    endtask

    task automatic test_limits_and_handoff();
        longint ceil_v;
        settle();
        write_reg(CFG_INSPIRATION_TIME, 16'd0);
        write_reg(CFG_EXPIRATION_TIME, 16'd0);
        write_reg(CFG_SET_PRESSURE, 16'hFFFF);
        write_reg(CFG_SET_VOLUME, 16'hFFFF);   // upper bits dropped
        write_reg(CFG_SPARE_INDEX, 16'hA5A5);
        advance_to(PHASE_START);
        push_tick(make_tick(1'b0, 1'b1, 16'd0, 24'd0, 16'd0));   // yields to new mode
        push_tick(calm_tick());                                  // init
        push_tick(calm_tick());                                  // home
        push_tick(make_tick(1'b0, 1'b0, 16'h7FFF, 24'h7FFFFF, 16'hFFFF)); // still moving
        push_tick(make_tick(1'b1, 1'b0, 16'h8000, 24'h800000, 16'd0));
        push_tick(calm_tick());                                  // expire
        push_tick(make_tick(1'b0, 1'b0, 16'h8000, 24'h7FFFFF, 16'hFFFF)); // start
        push_tick(make_tick(1'b1, 1'b1, 16'h7FFF, 24'h7FFFFF, 16'hFFFF)); // volume limit
        push_tick(make_tick(1'b0, 1'b1, 16'h7FFF, 24'h7FFFFF, 16'hFFFF)); // hold
        advance_to(PHASE_INHALE);
        push_tick(make_tick(1'b1, 1'b0, 16'd0, 24'h800000, 16'(POSITION_LIMIT)));
        push_tick(calm_tick());
        advance_to(PHASE_INHALE);
        ceil_v = volume_ceiling(16'sh8000);
        push_tick(make_tick(1'b1, 1'b0, 16'h8000, 24'(ceil_v), 16'(POSITION_LIMIT - 1)));
        advance_to(PHASE_INHALE);
        // -3/4 must round toward zero here, floor would miss the limit
        ceil_v = volume_ceiling(-16'sd1);
        push_tick(make_tick(1'b1, 1'b0, 16'hFFFF, 24'(ceil_v + 1), 16'd0));
        advance_to(PHASE_INHALE);
        ceil_v = volume_ceiling(16'sh7FFF);
        push_tick(make_tick(1'b1, 1'b0, 16'h7FFF, 24'(ceil_v + 1), 16'd0));
        push_tick(calm_tick());
    endtask

    // zero set pressure minus ramp goes negative, then the first step rolls it over
    task automatic test_target_wrap();
        settle();
        write_reg(CFG_INSPIRATION_TIME, 16'd1);
        write_reg(CFG_SET_PRESSURE, 16'd0);
        advance_to(PHASE_INHALE);
        push_tick(calm_tick());
        push_tick(calm_tick());
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : compare_reports
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat %h", $time, m_data);
            end else begin
                want = pending_reports.pop_front();
                flag_field("status_code", want.status_code, m_data.status_code);
                flag_field("drive_command", want.drive_command, m_data.drive_command);
                flag_field("pressure_target", want.pressure_target, m_data.pressure_target);
                flag_field("volume_command", want.volume_command, m_data.volume_command);
                flag_field("breath_count", want.breath_count, m_data.breath_count);
                flag_field("mode_handoff", want.mode_handoff, m_data.mode_handoff);
            end
        end
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : watchdog
        #(64'd20_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin : run_tests
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        sink_hold = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_random_breaths(350, 1'b0, 1'b0);   // power-on settings
        test_limits_and_handoff();
        test_target_wrap();
        for (int p = 0; p < 5; p++)
            test_random_breaths(220, 1'b1, p == 2);

        settle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/vvbs_pkg.sv
rtl/volume_ventilation_breath_sequencer.sv
sim/tb.sv
